[rtl/nsc_pkg.sv]
`default_nettype none

package nsc_pkg;

  localparam int unsigned SentenceBytesDefault = 128;
  localparam int unsigned HeaderLen = 6;
  localparam int unsigned KindCount = 4;

  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperF  = 8'h46;

  localparam logic [2:0] KindGga   = 3'd0;
  localparam logic [2:0] KindGsa   = 3'd1;
  localparam logic [2:0] KindRmc   = 3'd2;
  localparam logic [2:0] KindVtg   = 3'd3;
  localparam logic [2:0] KindOther = 3'd4;

  typedef logic [7:0] header_row_t [HeaderLen];

  localparam header_row_t HeaderGga = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41};
  localparam header_row_t HeaderGsa = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h41};
  localparam header_row_t HeaderRmc = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};
  localparam header_row_t HeaderVtg = '{8'h24, 8'h47, 8'h50, 8'h56, 8'h54, 8'h47};

  typedef struct packed {
    logic [2:0] sentence_kind;
    logic       checksum_ok;
    logic [7:0] computed_sum;
    logic       overflowed;
    logic       restarted;
  } result_t;

  // Header byte expected by one header at one position.
  function automatic logic [7:0] header_byte(input logic [1:0] kind, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (pos < 3'(HeaderLen)) begin
      unique case (kind)
        2'd0: ch = HeaderGga[pos];
        2'd1: ch = HeaderGsa[pos];
        2'd2: ch = HeaderRmc[pos];
        2'd3: ch = HeaderVtg[pos];
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

  // Upper-case hex digit: bit 4 set when the character is a valid digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [4:0] v;
    v = 5'd0;
    if (ch >= ChZero && ch <= ChNine) begin
      v = {1'b1, 4'(ch - ChZero)};
    end else if (ch >= ChUpperA && ch <= ChUpperF) begin
      v = {1'b1, 4'(ch - ChUpperA + 8'd10)};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/nsc_scan.sv]
`default_nettype none

module nsc_scan import nsc_pkg::*; #(
  parameter int unsigned SentenceBytes = SentenceBytesDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output result_t         result_o
);

  typedef enum logic [2:0] {
    PhBefore,
    PhHigh,
    PhLow,
    PhMatch,
    PhFail
  } phase_e;

  localparam logic [8:0] PosLimit = 9'(SentenceBytes - 2);

  logic [7:0] pos_q, pos_d;
  logic [7:0] xor_q, xor_d;
  phase_e     phase_q, phase_d;
  logic [3:0] nib_q, nib_d;
  logic [3:0] match_q, match_d;
  logic       ovf_q, ovf_d;
  logic       rst_seen_q, rst_seen_d;

  logic [7:0] pos_e, xor_e;
  phase_e     phase_e_w;
  logic [3:0] nib_e, match_e;
  logic       ovf_e, rst_e;
  logic [4:0] hex;
  logic [8:0] pos_inc;

  always_comb begin
    // Unexpected dollar: drop what came before, keep the dollar as first byte.
    pos_e     = pos_q;
    xor_e     = xor_q;
    phase_e_w = phase_q;
    nib_e     = nib_q;
    match_e   = match_q;
    ovf_e     = ovf_q;
    rst_e     = rst_seen_q;
    if (byte_i == ChDollar && pos_q != 8'd0) begin
      pos_e     = 8'd0;
      xor_e     = 8'd0;
      phase_e_w = PhBefore;
      nib_e     = 4'd0;
      match_e   = 4'hF;
      ovf_e     = 1'b0;
      rst_e     = 1'b1;
    end

    result_o.sentence_kind = KindOther;
    if (pos_e >= 8'(HeaderLen)) begin
      priority if (match_e[0]) result_o.sentence_kind = KindGga;
      else if (match_e[1]) result_o.sentence_kind = KindGsa;
      else if (match_e[2]) result_o.sentence_kind = KindRmc;
      else if (match_e[3]) result_o.sentence_kind = KindVtg;
      else result_o.sentence_kind = KindOther;
    end
    result_o.checksum_ok  = (phase_e_w == PhMatch) && !ovf_e;
    result_o.computed_sum = xor_e;
    result_o.overflowed   = ovf_e;
    result_o.restarted    = rst_e;

    hex     = hex_digit(byte_i);
    pos_inc = {1'b0, pos_e} + 9'd1;

    pos_d      = pos_e;
    xor_d      = xor_e;
    phase_d    = phase_e_w;
    nib_d      = nib_e;
    match_d    = match_e;
    ovf_d      = ovf_e;
    rst_seen_d = rst_e;

    if (byte_i == ChNewline) begin
      pos_d      = 8'd0;
      xor_d      = 8'd0;
      phase_d    = PhBefore;
      nib_d      = 4'd0;
      match_d    = 4'hF;
      ovf_d      = 1'b0;
      rst_seen_d = 1'b0;
    end else if (!ovf_e) begin
      if (pos_e < 8'(HeaderLen)) begin
        for (int k = 0; k < KindCount; k++) begin
          if (header_byte(2'(k), pos_e[2:0]) != byte_i) begin
            match_d[k] = 1'b0;
          end
        end
      end
      if (pos_e != 8'd0) begin
        unique case (phase_e_w)
          PhBefore: begin
            if (byte_i == ChStar) phase_d = PhHigh;
            else xor_d = xor_e ^ byte_i;
          end
          PhHigh: begin
            if (!hex[4]) begin
              phase_d = PhFail;
            end else begin
              nib_d   = hex[3:0];
              phase_d = PhLow;
            end
          end
          PhLow: begin
            if (hex[4] && {nib_e, hex[3:0]} == xor_e) phase_d = PhMatch;
            else phase_d = PhFail;
          end
          default: phase_d = phase_e_w;
        endcase
      end
      // Hold the position at the buffer limit and flag the sentence.
      if (pos_inc >= PosLimit) begin
        ovf_d = 1'b1;
      end else begin
        pos_d = pos_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 8'd0;
      xor_q      <= 8'd0;
      phase_q    <= PhBefore;
      nib_q      <= 4'd0;
      match_q    <= 4'hF;
      ovf_q      <= 1'b0;
      rst_seen_q <= 1'b0;
    end else if (step_i) begin
      pos_q      <= pos_d;
      xor_q      <= xor_d;
      phase_q    <= phase_d;
      nib_q      <= nib_d;
      match_q    <= match_d;
      ovf_q      <= ovf_d;
      rst_seen_q <= rst_seen_d;
    end
  end

endmodule

`default_nettype wire

[rtl/nmea_sentence_checker.sv]
// NMEA 0183 sentence checker.
// Feed received GPS characters, one per transaction, on the s_axis channel
// (tdata = rx_byte). Each newline character produces one transaction on the
// m_axis channel carrying the sentence kind, checksum verdict, computed XOR,
// overflow flag and restart flag; every other character produces nothing.
// A newline accepted into the input register moves, once the result slot is
// free, through the scan stage into the result register (m_axis_tvalid_o).
// Throughput: one character per cycle; the per-byte XOR, header compare and
// hex decode all sit between the input register and the result register.
// While a result waits on m_axis the input register still takes one more
// character; when the result register is full and m_axis_tready_i is low the
// scan stage holds, the input register fills and s_axis_tready_o drops.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// scan state to the start of a sentence, with no restart pending.
// SentenceBytes sets the buffer bound: a sentence is flagged overflowed when
// its stored length would reach SentenceBytes-2, and reports a failed check.
`default_nettype none

module nmea_sentence_checker import nsc_pkg::*; #(
  parameter int unsigned SentenceBytes = SentenceBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [2:0] sentence_kind, [3] checksum_ok, [11:4] computed_sum,
  // [12] overflowed, [13] restarted, [15:14] zero
  output logic [15:0]      m_axis_tdata_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  result_t    out_res_q;
  result_t    scan_res;
  logic       advance;

  // Move the held byte through the scan stage when the result slot is free.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  nsc_scan #(
    .SentenceBytes(SentenceBytes)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (in_byte_q),
    .result_o(scan_res)
  );

  // Result register: load on a newline, drop once the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= (in_byte_q == ChNewline);
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_byte_q == ChNewline) begin
      out_res_q <= scan_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_res_q.restarted, out_res_q.overflowed,
                            out_res_q.computed_sum, out_res_q.checksum_ok,
                            out_res_q.sentence_kind};

endmodule

`default_nettype wire
